[rtl/tfi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween frame interpolator package
// Shared widths, payload types and command/register codes.
// ----------------------------------------------------------------------------
package tfi_pkg;

	localparam int VAL_W      = 24;
	localparam int FRAME_W    = 16;
	localparam int DELTA_W    = 25;
	localparam int RUNS_W     = 11;
	localparam int REPCNT_W   = 10;
	localparam int CFG_IDX_W  = 3;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [FRAME_W-1:0]      frame_t;
	typedef logic [1:0]              kind_t;

	// command kinds
	localparam kind_t KIND_START_ABS = 2'd0;
	localparam kind_t KIND_START_REL = 2'd1;
	localparam kind_t KIND_STOP      = 2'd2;
	localparam kind_t KIND_TICK      = 2'd3;

	// repeat modes
	localparam logic [1:0] REP_SINGLE  = 2'd0;
	localparam logic [1:0] REP_COUNTED = 2'd1;
	localparam logic [1:0] REP_ENDLESS = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YOYO_ENABLE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BACKWARD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 3'd5;

	localparam value_t VAL_MAX = 24'sh7FFFFF;
	localparam value_t VAL_MIN = 24'sh800000;

endpackage

[rtl/tfi_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface tfi_in_if
	import tfi_pkg::*;
();
	logic   valid;
	logic   ready;
	kind_t  kind;
	value_t value_a;
	value_t value_b;

	modport source (output valid, output kind, output value_a, output value_b, input ready);
	modport sink   (input valid, input kind, input value_a, input value_b, output ready);
endinterface

[rtl/tfi_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween result channel
// Valid/ready channel carrying one position report item.
// ----------------------------------------------------------------------------
interface tfi_out_if
	import tfi_pkg::*;
();
	logic   valid;
	logic   ready;
	value_t position;
	logic   finished;
	frame_t frame_index;

	modport source (output valid, output position, output finished, output frame_index,
		input ready);
	modport sink   (input valid, input position, input finished, input frame_index,
		output ready);
endinterface

[rtl/tween_frame_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween frame interpolator core
// Linear Q16.8 position animator with repeat and yoyo control.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command items (start absolute, start relative, stop, frame
//   tick); every accepted item yields exactly one report item on out_ch with
//   the saturated position, the finished flag and the frame index.
//   cfg_we/cfg_index/cfg_data write the six setup registers; write them only
//   while the core is idle with every report delivered.
// Sequencing and throughput:
//   Start, stop, snapping ticks and ticks while finished go straight from
//   accept to report. An interpolating tick runs a bit-serial multiplier
//   (16 steps, one bit of the frame term per cycle) and then a restoring
//   divider (25 steps, one quotient bit per cycle), then applies the
//   quotient and reports; the next item is taken once the report is in the
//   output register. The shared shift/add datapath allows one item in
//   flight at a time.
// Reset:
//   arst_n clears the animation state; the core comes up finished at
//   position zero with the default registers.
// Stall:
//   A report waits in the output register while out_ch.ready is low; the
//   core still accepts and works on the next item and holds its report
//   until the output register frees.
// ----------------------------------------------------------------------------
module tween_frame_interpolator_core
	import tfi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	tfi_in_if.sink               in_ch,
	tfi_out_if.source            out_ch
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam int PROD_W = DELTA_W + FRAME_W;  // multiplier register width
	localparam int QUO_W  = DELTA_W;            // quotient never exceeds |delta|
	localparam int CNT_W  = 5;
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FRAME_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

	// Saturate a wide signed sum into Q16.8.
	function automatic value_t sat_val(input logic signed [VAL_W+2:0] v);
		value_t r;
		if (v > (VAL_W+3)'(VAL_MAX))
			r = VAL_MAX;
		else if (v < (VAL_W+3)'(VAL_MIN))
			r = VAL_MIN;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- setup
	logic [1:0]          repeat_mode_q;
	logic [REPCNT_W-1:0] repeat_count_q;
	logic                yoyo_enable_q;
	logic                start_backward_q;
	frame_t              frame_count_q;
	value_t              position_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_mode_q     <= REP_SINGLE;
			repeat_count_q    <= REPCNT_W'(1);
			yoyo_enable_q     <= 1'b0;
			start_backward_q  <= 1'b0;
			frame_count_q     <= FRAME_W'(2);
			position_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPEAT_MODE:     repeat_mode_q     <= cfg_data[1:0];
				CFG_REPEAT_COUNT:    repeat_count_q    <= cfg_data[REPCNT_W-1:0];
				CFG_YOYO_ENABLE:     yoyo_enable_q     <= cfg_data[0];
				CFG_START_BACKWARD:  start_backward_q  <= cfg_data[0];
				CFG_FRAME_COUNT:     frame_count_q     <= cfg_data[FRAME_W-1:0];
				CFG_POSITION_OFFSET: position_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- animation state
	logic [2:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	value_t                     run_start_q;
	value_t                     run_end_q;
	logic signed [DELTA_W-1:0]  run_delta_q;
	value_t                     current_q;
	frame_t                     frame_pos_q;
	logic                       reversed_q;
	logic [RUNS_W-1:0]          runs_left_q;
	logic                       endless_q;

	// serial datapath
	logic [PROD_W-1:0]  p_q;      // product, then dividend/quotient shifter
	logic [FRAME_W-1:0] r_q;      // partial remainder
	logic [DELTA_W-1:0] mag_q;    // |run_delta|
	logic               neg_q;    // run_delta sign
	logic [FRAME_W-1:0] div_q;    // effective frame count - 1

	// output register
	logic   out_valid_q;
	value_t out_pos_q;
	logic   out_fin_q;
	frame_t out_idx_q;

	logic accept;
	logic finished;
	logic out_free;
	logic emit_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign finished    = (runs_left_q == '0) && !endless_q;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign emit_load   = (state_q == ST_EMIT) && out_free;

	// ---------------------------------------------------- start commands
	value_t              rel_end;
	value_t              br_from;
	value_t              br_to;
	logic [RUNS_W-1:0]   br_runs;

	always_comb begin
		rel_end = sat_val((VAL_W+3)'(run_end_q) + (VAL_W+3)'(in_ch.value_a));
		if (in_ch.kind == KIND_START_ABS) begin
			br_from = in_ch.value_a;
			br_to   = in_ch.value_b;
		end else begin
			br_from = current_q;
			br_to   = rel_end;
		end
		br_runs = (repeat_mode_q == REP_COUNTED) ? RUNS_W'(repeat_count_q) : RUNS_W'(1);
		if (yoyo_enable_q)
			br_runs = {br_runs[RUNS_W-2:0], 1'b0};
	end

	// ---------------------------------------------------- frame advance
	frame_t              fc_eff;
	logic [FRAME_W:0]    idx_inc;
	logic [FRAME_W:0]    idx_new;
	logic                idx_wrap;
	logic                idx_snap;
	logic                rev_new;
	frame_t              mul_term;

	always_comb begin
		fc_eff   = (frame_count_q < FRAME_W'(2)) ? FRAME_W'(2) : frame_count_q;
		idx_inc  = {1'b0, frame_pos_q} + (FRAME_W+1)'(1);
		idx_wrap = idx_inc > {1'b0, fc_eff};
		rev_new  = reversed_q;
		idx_new  = idx_inc;
		if (idx_wrap) begin
			if (yoyo_enable_q) begin
				rev_new = !reversed_q;
				idx_new = (FRAME_W+1)'(2);
			end else begin
				idx_new = (FRAME_W+1)'(1);
			end
		end
		idx_snap = idx_new == {1'b0, fc_eff};
		mul_term = idx_new[FRAME_W-1:0] - FRAME_W'(1);
	end

	// ---------------------------------------------------- serial arithmetic
	logic [DELTA_W:0]     mul_sum;
	logic [PROD_W-1:0]    p_next;
	logic [FRAME_W:0]     div_trial;
	logic [FRAME_W:0]     div_diff;
	logic                 div_ge;
	logic [FRAME_W-1:0]   r_next;

	always_comb begin
		// add the multiplicand under the current multiplier bit, shift right
		mul_sum   = {1'b0, p_q[PROD_W-1:FRAME_W]} + (p_q[0] ? {1'b0, mag_q} : '0);
		p_next    = {mul_sum, p_q[FRAME_W-1:1]};
		// bring down the next dividend bit, trial subtract
		div_trial = {r_q, p_q[QUO_W-1]};
		div_diff  = div_trial - {1'b0, div_q};
		div_ge    = div_trial >= {1'b0, div_q};
		r_next    = div_ge ? div_diff[FRAME_W-1:0] : div_trial[FRAME_W-1:0];
	end

	// apply the signed quotient to the run end points
	logic signed [DELTA_W:0]  part;
	logic signed [VAL_W+2:0]  base_ext;
	logic signed [VAL_W+2:0]  interp_sum;
	value_t                   interp_val;

	always_comb begin
		part       = neg_q ? -$signed({1'b0, p_q[QUO_W-1:0]}) : $signed({1'b0, p_q[QUO_W-1:0]});
		base_ext   = reversed_q ? (VAL_W+3)'(run_end_q) : (VAL_W+3)'(run_start_q);
		interp_sum = reversed_q ? base_ext - (VAL_W+3)'(part) : base_ext + (VAL_W+3)'(part);
		interp_val = sat_val(interp_sum);
	end

	// ---------------------------------------------------- control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			run_start_q <= '0;
			run_end_q   <= '0;
			run_delta_q <= '0;
			current_q   <= '0;
			frame_pos_q <= '0;
			reversed_q  <= 1'b0;
			runs_left_q <= '0;
			endless_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EMIT;
						case (in_ch.kind)
							KIND_START_ABS, KIND_START_REL: begin
								run_start_q <= br_from;
								run_end_q   <= br_to;
								run_delta_q <= DELTA_W'(br_to) - DELTA_W'(br_from);
								frame_pos_q <= '0;
								reversed_q  <= start_backward_q;
								if (repeat_mode_q == REP_ENDLESS) begin
									endless_q   <= 1'b1;
									runs_left_q <= '0;
								end else begin
									endless_q   <= 1'b0;
									runs_left_q <= br_runs;
								end
							end
							KIND_STOP: begin
								runs_left_q <= '0;
								endless_q   <= 1'b0;
								current_q   <= in_ch.value_a;
							end
							KIND_TICK: begin
								if (!finished) begin
									frame_pos_q <= idx_new[FRAME_W-1:0];
									reversed_q  <= rev_new;
									if (idx_snap) begin
										current_q <= rev_new ? run_start_q : run_end_q;
										if (!endless_q && runs_left_q != '0)
											runs_left_q <= runs_left_q - RUNS_W'(1);
									end else begin
										state_q <= ST_MUL;
										cnt_q   <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == DIV_LAST)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					current_q <= interp_val;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath shifters, no reset needed
	always_ff @(posedge clk) begin
		if (accept && in_ch.kind == KIND_TICK) begin
			// load multiplicand magnitude, sign, divisor and multiplier
			mag_q <= run_delta_q[DELTA_W-1] ? DELTA_W'(-run_delta_q) : DELTA_W'(run_delta_q);
			neg_q <= run_delta_q[DELTA_W-1];
			div_q <= fc_eff - FRAME_W'(1);
			p_q   <= {{DELTA_W{1'b0}}, mul_term};
		end else if (state_q == ST_MUL) begin
			p_q <= p_next;
			// high dividend bits already sit below the divisor
			if (cnt_q == MUL_LAST)
				r_q <= {1'b0, p_next[PROD_W-2:QUO_W]};
		end else if (state_q == ST_DIV) begin
			r_q            <= r_next;
			p_q[QUO_W-1:0] <= {p_q[QUO_W-2:0], div_ge};
		end
	end

	// ---------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_pos_q <= sat_val((VAL_W+3)'(current_q) + (VAL_W+3)'(position_offset_q));
			out_fin_q <= finished;
			out_idx_q <= frame_pos_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.position    = out_pos_q;
	assign out_ch.finished    = out_fin_q;
	assign out_ch.frame_index = out_idx_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween frame interpolator core testbench
// Drives command items into the core and checks every position report against
// an in-bench model of the animator: absolute and relative starts, stops,
// frame ticks, repeats, yoyo, saturation and register changes between runs.
// ----------------------------------------------------------------------------
module tb_top;
	import tfi_pkg::*;

	// Hard stop well beyond the slowest legal run of about 1300 items plus stalls.
	localparam int TIMEOUT_NS  = 5_000_000;
	localparam int DRAIN_TAIL  = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		value_t position;
		logic   finished;
		frame_t frame_index;
	} report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;

	tfi_in_if  in_ch();
	tfi_out_if out_ch();

	tween_frame_interpolator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// ------------------------------------------------------------------------
	// Animator model: register copies and run state
	// ------------------------------------------------------------------------
	logic [1:0]        cfg_mode;
	logic [9:0]        cfg_count;
	logic              cfg_yoyo;
	logic              cfg_back;
	logic [15:0]       cfg_frames;
	value_t            cfg_offset;

	value_t            tw_start;
	value_t            tw_end;
	logic signed [24:0] tw_delta;
	value_t            tw_cur;
	frame_t            tw_frame;
	logic              tw_rev;
	logic [10:0]       tw_runs;
	logic              tw_endless;

	report_t pending_reports[$];

	// Knobs and bookkeeping
	int  src_gap_pct;
	int  sink_stall_pct;
	bit  hold_off_req;
	int  n_errors;
	int  reports_checked;
	int  reg_writes;
	int  kinds_sent[4];

	// ------------------------------------------------------------------------
	// Clock and timeout
	// ------------------------------------------------------------------------
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tween_frame_interpolator_core test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model functions
	// ------------------------------------------------------------------------

	// Clamp to the Q16.8 range of the datapath.
	function automatic value_t clamp_q16_8(longint v);
		if (v > longint'(VAL_MAX))
			return VAL_MAX;
		if (v < longint'(VAL_MIN))
			return VAL_MIN;
		return value_t'(v);
	endfunction

	function automatic bit anim_done();
		return tw_runs == 11'd0 && !tw_endless;
	endfunction

	// Load a new run; the run count depends on the repeat mode at this moment.
	function automatic void load_run(value_t from, value_t to);
		tw_start = from;
		tw_end   = to;
		tw_delta = 25'(longint'(to) - longint'(from));
		tw_frame = '0;
		tw_rev   = cfg_back;
		if (cfg_mode == REP_ENDLESS) begin
			tw_endless = 1'b1;
			tw_runs    = '0;
		end else begin
			tw_endless = 1'b0;
			tw_runs    = (cfg_mode == REP_COUNTED) ? {1'b0, cfg_count} : 11'd1;
			if (cfg_yoyo)
				tw_runs = tw_runs << 1;
		end
	endfunction

	// One frame tick: advance the index, wrap at run end, then snap or
	// interpolate with the quotient truncated toward zero.
	function automatic void advance_frame();
		longint fc;
		longint idx;
		longint part;
		fc = (cfg_frames < 16'd2) ? 2 : cfg_frames;
		if (anim_done())
			return;
		idx = tw_frame + 1;
		if (idx > fc) begin
			if (cfg_yoyo) begin
				tw_rev = ~tw_rev;
				idx = 2;
			end else begin
				idx = 1;
			end
		end
		tw_frame = frame_t'(idx);
		if (idx == fc) begin
			tw_cur = tw_rev ? tw_start : tw_end;
			if (!tw_endless && tw_runs != 11'd0)
				tw_runs = tw_runs - 11'd1;
		end else begin
			part = (longint'(tw_delta) * (idx - 1)) / (fc - 1);
			tw_cur = tw_rev ? clamp_q16_8(longint'(tw_end) - part)
				: clamp_q16_8(longint'(tw_start) + part);
		end
	endfunction

	// Apply one command item and return the report the core must give for it.
	function automatic report_t predict_report(kind_t k, value_t a, value_t b);
		report_t r;
		case (k)
			KIND_START_ABS: load_run(a, b);
			KIND_START_REL: load_run(tw_cur, clamp_q16_8(longint'(tw_end) + longint'(a)));
			KIND_STOP: begin
				tw_runs    = '0;
				tw_endless = 1'b0;
				tw_cur     = a;
			end
			default: advance_frame();
		endcase
		r.position    = clamp_q16_8(longint'(tw_cur) + longint'(cfg_offset));
		r.finished    = anim_done();
		r.frame_index = tw_frame;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Report side: random stalls plus a counted long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		int hold_left;
		bit hold_seen;
		// start a hold-off on the rising edge of the request
		if (hold_off_req && !hold_seen)
			hold_left = HOLD_CYCLES;
		hold_seen = hold_off_req;
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic void note_mismatch(string field, longint want, longint got);
		n_errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endfunction

	// Check each accepted report against the oldest expectation.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("unexpected report, position", 0, $signed(out_ch.position));
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (out_ch.position !== want.position)
					note_mismatch("position", $signed(want.position),
						$signed(out_ch.position));
				if (out_ch.finished !== want.finished)
					note_mismatch("finished", want.finished, out_ch.finished);
				if (out_ch.frame_index !== want.frame_index)
					note_mismatch("frame_index", want.frame_index, out_ch.frame_index);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------------

	// Offer one item, idling first at random; hold valid high until it is
	// taken and leave it high so back-to-back items need no extra edge.
	task automatic issue_cmd(kind_t k, value_t a, value_t b);
		if ($urandom_range(99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_gap_pct);
		end
		in_ch.valid   <= 1'b1;
		in_ch.kind    <= k;
		in_ch.value_a <= a;
		in_ch.value_b <= b;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		pending_reports.push_back(predict_report(k, a, b));
		kinds_sent[k]++;
	endtask

	task automatic tick();
		issue_cmd(KIND_TICK, value_t'($urandom), value_t'($urandom));
	endtask

	// Drop valid and wait until every report is back; the core is idle then.
	task automatic settle();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	// Write one register; lower the strobe on the next edge.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_REPEAT_MODE:     cfg_mode   = data[1:0];
			CFG_REPEAT_COUNT:    cfg_count  = data[9:0];
			CFG_YOYO_ENABLE:     cfg_yoyo   = data[0];
			CFG_START_BACKWARD:  cfg_back   = data[0];
			CFG_FRAME_COUNT:     cfg_frames = data[15:0];
			CFG_POSITION_OFFSET: cfg_offset = value_t'(data);
			default: ;
		endcase
		reg_writes++;
	endtask

	// Drain, then program all six registers.
	task automatic setup_run(logic [1:0] mode, int count, bit yoyo, bit back, int frames,
		value_t offset);
		settle();
		write_reg(CFG_REPEAT_MODE, VAL_W'(mode));
		write_reg(CFG_REPEAT_COUNT, VAL_W'(count));
		write_reg(CFG_YOYO_ENABLE, VAL_W'(yoyo));
		write_reg(CFG_START_BACKWARD, VAL_W'(back));
		write_reg(CFG_FRAME_COUNT, VAL_W'(frames));
		write_reg(CFG_POSITION_OFFSET, offset);
	endtask

	// Mostly moderate values, with extremes and full-width noise mixed in.
	function automatic value_t random_q16_8();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return VAL_MAX;
		if (r < 10)
			return VAL_MIN;
		if (r < 45)
			return value_t'($urandom);
		return value_t'(int'($urandom_range(200000)) - 100000);
	endfunction

	// Pick a register setting; short runs dominate so runs finish and wrap.
	task automatic randomize_settings();
		int r;
		int frames;
		int count;
		value_t offset;
		r = $urandom_range(99);
		if (r < 6)
			frames = $urandom_range(1);
		else if (r < 9)
			frames = 65535;
		else if (r < 12)
			frames = $urandom_range(65535);
		else
			frames = $urandom_range(9, 2);
		r = $urandom_range(99);
		if (r < 8)
			count = 0;
		else if (r < 12)
			count = 1023;
		else if (r < 18)
			count = $urandom_range(1023);
		else
			count = $urandom_range(4, 1);
		r = $urandom_range(99);
		if (r < 8)
			offset = VAL_MAX;
		else if (r < 16)
			offset = VAL_MIN;
		else if (r < 40)
			offset = value_t'($urandom);
		else
			offset = value_t'(int'($urandom_range(4096)) - 2048);
		setup_run(2'($urandom_range(3)), count, 1'($urandom_range(1)),
			1'($urandom_range(1)), frames, offset);
	endtask

	task automatic random_start();
		if ($urandom_range(99) < 65)
			issue_cmd(KIND_START_ABS, random_q16_8(), random_q16_8());
		else
			issue_cmd(KIND_START_REL, random_q16_8(), value_t'($urandom));
	endtask

	// Each episode: new settings, usually a fresh start, then mostly ticks.
	// A quarter of episodes keep the old run going so register changes land
	// mid-run. Restart soon after a run finishes so ticks keep doing work.
	task automatic run_episodes(int n);
		int r;
		repeat (n) begin
			randomize_settings();
			if ($urandom_range(3) != 0)
				random_start();
			repeat (29) begin
				r = $urandom_range(99);
				if (anim_done() && r < 50)
					random_start();
				else if (r < 86)
					tick();
				else if (r < 91)
					issue_cmd(KIND_STOP, random_q16_8(), value_t'($urandom));
				else if (r < 98)
					random_start();
				else
					issue_cmd(kind_t'($urandom_range(3)), value_t'($urandom),
						value_t'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Core comes up finished at zero: a tick changes nothing, a stop forces.
	task automatic test_idle_after_reset();
		tick();
		issue_cmd(KIND_STOP, value_t'(24'sh000123), '0);
	endtask

	// Full-scale run, short frame counts, unused repeat mode, offset and
	// relative-end saturation, counted start with a zero count.
	task automatic test_saturation();
		setup_run(REP_SINGLE, 1, 1'b0, 1'b0, 2, '0);
		issue_cmd(KIND_START_ABS, VAL_MIN, VAL_MAX);
		tick();
		tick();
		tick();
		setup_run(2'd3, 1, 1'b0, 1'b0, 0, VAL_MAX);
		issue_cmd(KIND_START_REL, VAL_MAX, '0);
		tick();
		tick();
		issue_cmd(KIND_STOP, VAL_MIN, VAL_MAX);
		setup_run(REP_COUNTED, 0, 1'b0, 1'b0, 1, VAL_MIN);
		issue_cmd(KIND_START_ABS, VAL_MIN, '0);
		tick();
	endtask

	// Counted yoyo run started backward: reverse at each end, restart at
	// frame two; then stop mid-run keeping index and direction.
	task automatic test_counted_yoyo();
		setup_run(REP_COUNTED, 2, 1'b1, 1'b1, 4, '0);
		issue_cmd(KIND_START_ABS, '0, value_t'(1000));
		repeat (6)
			tick();
		issue_cmd(KIND_STOP, value_t'(123), '0);
	endtask

	// Endless relative run with a negative distance: truncation toward zero
	// and wrap back to frame one without yoyo.
	task automatic test_endless_relative();
		setup_run(REP_ENDLESS, 5, 1'b0, 1'b0, 3, value_t'(-256));
		issue_cmd(KIND_START_REL, value_t'(-5000), '0);
		repeat (4)
			tick();
	endtask

	// Largest frame count, then shrink it to the current index.
	task automatic test_frame_count_change();
		setup_run(REP_ENDLESS, 5, 1'b0, 1'b0, 65535, '0);
		tick();
		setup_run(REP_ENDLESS, 5, 1'b0, 1'b0, 2, '0);
		tick();
		issue_cmd(KIND_STOP, VAL_MAX, '0);
	endtask

	// Hold the report side off for a long stretch while items keep coming,
	// so the core fills its output register and stops taking input.
	task automatic test_backpressure();
		src_gap_pct = 0;
		sink_stall_pct = 0;
		setup_run(REP_COUNTED, 1023, 1'b1, 1'b0, 65535, '0);
		hold_off_req = 1'b1;
		issue_cmd(KIND_START_ABS, random_q16_8(), random_q16_8());
		repeat (12)
			tick();
		settle();
		hold_off_req = 1'b0;
	endtask

	// Random animation in three idling phases.
	task automatic test_random_animation();
		src_gap_pct = 11;
		sink_stall_pct = 62;
		run_episodes(13);
		src_gap_pct = 62;
		sink_stall_pct = 11;
		run_episodes(13);
		src_gap_pct = 0;
		sink_stall_pct = 0;
		run_episodes(13);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// Quiet inputs and the model's reset view.
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_ch.valid   = 1'b0;
		in_ch.kind    = KIND_TICK;
		in_ch.value_a = '0;
		in_ch.value_b = '0;
		hold_off_req  = 1'b0;
		src_gap_pct   = 11;
		sink_stall_pct = 62;
		n_errors      = 0;
		reports_checked = 0;
		reg_writes    = 0;
		kinds_sent    = '{default: 0};
		cfg_mode      = REP_SINGLE;
		cfg_count     = 10'd1;
		cfg_yoyo      = 1'b0;
		cfg_back      = 1'b0;
		cfg_frames    = 16'd2;
		cfg_offset    = '0;
		tw_start      = '0;
		tw_end        = '0;
		tw_delta      = '0;
		tw_cur        = '0;
		tw_frame      = '0;
		tw_rev        = 1'b0;
		tw_runs       = '0;
		tw_endless    = 1'b0;

		// Hold reset, then release it on an edge.
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_saturation();
		test_counted_yoyo();
		test_endless_relative();
		test_frame_count_change();
		test_backpressure();
		test_random_animation();

		// Drain, then give a stray report time to show up.
		settle();
		repeat (DRAIN_TAIL)
			@(posedge clk);

		$display("Sent %0d items: %0d absolute starts, %0d relative starts, %0d stops, %0d ticks",
			kinds_sent[0] + kinds_sent[1] + kinds_sent[2] + kinds_sent[3],
			kinds_sent[KIND_START_ABS], kinds_sent[KIND_START_REL],
			kinds_sent[KIND_STOP], kinds_sent[KIND_TICK]);
		$display("Checked %0d reports over %0d register writes, with stalls on both sides",
			reports_checked, reg_writes);
		if (pending_reports.size() != 0)
			$display("%0d reports never arrived", pending_reports.size());

		if (n_errors == 0 && pending_reports.size() == 0) begin
			$display("tween_frame_interpolator_core test passed");
		end else begin
			$display("tween_frame_interpolator_core test failed");
		end
		$finish;
	end

endmodule
